@@ hdl/prtc_pkg.sv @@
// Shared types and constants for the pulse rate tone classifier.
// Used by every module of the block but prtc_div; depends on nothing.
`default_nettype none
package prtc_pkg;

  localparam int DEB_W = 16;
  localparam int WT_W  = 20;
  localparam int WC_W  = 4;
  localparam int RATE_W = 16;
  localparam int PR_W  = 20;
  localparam int CLS_W = 2;
  localparam int CONF_W = 7;
  localparam int CYC_W = 24;
  localparam int DEN_W = WC_W + WT_W;
  localparam int CFG_W = 20;
  localparam int IDX_W = 3;

  localparam int TICKS_PER_SECOND_DEF = 1000000;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd40;
  localparam logic [WT_W-1:0]   WINDOW_TICKS_RST = 20'd200000;
  localparam logic [WC_W-1:0]   WINDOW_COUNT_RST = 4'd5;
  localparam logic [RATE_W-1:0] NO_SIGNAL_RST = 16'd50;
  localparam logic [RATE_W-1:0] RATE_A_RST = 16'd547;
  localparam logic [RATE_W-1:0] RATE_B_RST = 16'd312;

  localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_TICKS = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_COUNT = 3'd2;
  localparam logic [IDX_W-1:0] REG_NO_SIGNAL    = 3'd3;
  localparam logic [IDX_W-1:0] REG_RATE_A       = 3'd4;
  localparam logic [IDX_W-1:0] REG_RATE_B       = 3'd5;

  localparam logic [CLS_W-1:0] CLS_NONE = 2'd0;
  localparam logic [CLS_W-1:0] CLS_A    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_B    = 2'd2;

  localparam logic [CONF_W-1:0] CONF_MAX = 7'd100;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_RDIV_GO,
    BK_RDIV_WAIT,
    BK_CLS,
    BK_CDIV_GO,
    BK_CDIV_WAIT,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

@@ hdl/prtc_front.sv @@
// Front part: debounces edges and counts pulses over windows and cycles.
// Pushes the pulse total of each finished cycle into the queue. Uses prtc_pkg.
`default_nettype none
module prtc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tick_en,
  input  wire logic                        falling_edge,
  input  wire logic [prtc_pkg::DEB_W-1:0]  debounce_ticks,
  input  wire logic [prtc_pkg::WT_W-1:0]   window_ticks,
  input  wire logic [prtc_pkg::WC_W-1:0]   window_count,
  output logic                             q_push,
  output logic [prtc_pkg::CYC_W-1:0]       q_data
);

  localparam logic [prtc_pkg::DEB_W-1:0] DEB_MAX = '1;
  localparam logic [prtc_pkg::WT_W-1:0]  WIN_MAX = '1;
  localparam logic [prtc_pkg::CYC_W-1:0] CYC_MAX = '1;
  localparam logic [prtc_pkg::WC_W-1:0]  IDX_MAX = '1;

  logic [prtc_pkg::DEB_W-1:0] ticks_since_pulse, ticks_since_pulse_next;
  logic [prtc_pkg::WT_W-1:0]  window_pulses, window_pulses_next;
  logic [prtc_pkg::WT_W-1:0]  window_elapsed, window_elapsed_next;
  logic [prtc_pkg::WC_W-1:0]  window_index, window_index_next;
  logic [prtc_pkg::CYC_W-1:0] cycle_pulses, cycle_pulses_next;

  logic [prtc_pkg::DEB_W-1:0] tsp_inc;
  logic                       counted;
  logic [prtc_pkg::WT_W-1:0]  wp_inc, we_inc, wt_eff;
  logic [prtc_pkg::WC_W-1:0]  wi_inc, wc_eff;
  logic [prtc_pkg::CYC_W:0]   sum;
  logic [prtc_pkg::CYC_W-1:0] sum_sat;

  always_comb begin
    wt_eff = (window_ticks == '0) ? prtc_pkg::WT_W'(1) : window_ticks;
    wc_eff = (window_count == '0) ? prtc_pkg::WC_W'(1) : window_count;
    tsp_inc = (ticks_since_pulse == DEB_MAX) ? ticks_since_pulse
                                             : ticks_since_pulse + 1'b1;
    counted = falling_edge && (tsp_inc > debounce_ticks);
    wp_inc = (counted && window_pulses != WIN_MAX) ? window_pulses + 1'b1 : window_pulses;
    we_inc = (window_elapsed == WIN_MAX) ? window_elapsed : window_elapsed + 1'b1;
    wi_inc = (window_index == IDX_MAX) ? window_index : window_index + 1'b1;
    sum = {1'b0, cycle_pulses} + (prtc_pkg::CYC_W + 1)'(wp_inc);
    sum_sat = sum[prtc_pkg::CYC_W] ? CYC_MAX : sum[prtc_pkg::CYC_W-1:0];

    ticks_since_pulse_next = counted ? '0 : tsp_inc;
    window_pulses_next = wp_inc;
    window_elapsed_next = we_inc;
    window_index_next = window_index;
    cycle_pulses_next = cycle_pulses;
    q_push = 1'b0;
    q_data = sum_sat;
    if (we_inc >= wt_eff) begin
      window_pulses_next = '0;
      window_elapsed_next = '0;
      if (wi_inc >= wc_eff) begin
        q_push = tick_en;
        window_index_next = '0;
        cycle_pulses_next = '0;
      end else begin
        window_index_next = wi_inc;
        cycle_pulses_next = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_pulse <= DEB_MAX;
      window_pulses <= '0;
      window_elapsed <= '0;
      window_index <= '0;
      cycle_pulses <= '0;
    end else if (tick_en) begin
      ticks_since_pulse <= ticks_since_pulse_next;
      window_pulses <= window_pulses_next;
      window_elapsed <= window_elapsed_next;
      window_index <= window_index_next;
      cycle_pulses <= cycle_pulses_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/prtc_fifo.sv @@
// Short queue of cycle pulse totals between the front and back parts.
// Depth comes from prtc_pkg.
`default_nettype none
module prtc_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr,
  input  wire logic [prtc_pkg::CYC_W-1:0] wdata,
  output logic                            full,
  input  wire logic                       rd,
  output logic                            empty,
  output logic [prtc_pkg::CYC_W-1:0]      rdata
);

  localparam int DEPTH = prtc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [prtc_pkg::CYC_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_wr, do_rd;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/prtc_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the back part.
// Depends on nothing beyond its parameters.
`default_nettype none
module prtc_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             qbit;

  assign quot = q;

  always_comb begin
    rem_sh = {rem, q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den};
    qbit = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= num;
    end else if (busy) begin
      rem <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q <= {q[NUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/prtc_back.sv @@
// Back part: turns a cycle pulse total into rate, class and confidence.
// Uses prtc_pkg and prtc_div; holds the result register seen by the user.
`default_nettype none
module prtc_back #(
  parameter int TICKS_PER_SECOND = prtc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [prtc_pkg::CYC_W-1:0]  q_data,
  input  wire logic [prtc_pkg::WT_W-1:0]   window_ticks,
  input  wire logic [prtc_pkg::WC_W-1:0]   window_count,
  input  wire logic [prtc_pkg::RATE_W-1:0] no_signal_rate,
  input  wire logic [prtc_pkg::RATE_W-1:0] rate_a,
  input  wire logic [prtc_pkg::RATE_W-1:0] rate_b,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [prtc_pkg::PR_W-1:0]        pulse_rate,
  output logic [prtc_pkg::CLS_W-1:0]       rate_class,
  output logic [prtc_pkg::CONF_W-1:0]      confidence
);

  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int NUM_W = prtc_pkg::CYC_W + TPS_W;
  localparam int DEN_W = prtc_pkg::DEN_W;
  localparam int D_W = prtc_pkg::PR_W + 1;
  localparam logic [TPS_W-1:0] TPS_V = TPS_W'(TICKS_PER_SECOND);
  localparam logic [prtc_pkg::PR_W-1:0] PR_MAX = '1;

  prtc_pkg::back_state_t state, state_next;

  logic [prtc_pkg::CYC_W-1:0]  cyc;
  logic [NUM_W-1:0]            num;
  logic [DEN_W-1:0]            den;
  logic [prtc_pkg::PR_W-1:0]   rate;
  logic [prtc_pkg::CLS_W-1:0]  cls;
  logic [prtc_pkg::CONF_W-1:0] conf;
  logic                        out_valid;

  logic                        div_start, div_done;
  logic [NUM_W-1:0]            quot;

  logic [prtc_pkg::WT_W-1:0]   wt_eff;
  logic [prtc_pkg::WC_W-1:0]   wc_eff;
  logic [D_W-1:0]              da, db, d;
  logic [D_W-1:0]              two_r, sum_ab;
  logic [prtc_pkg::RATE_W-1:0] sep;
  logic                        load_out;

  prtc_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    wt_eff = (window_ticks == '0) ? prtc_pkg::WT_W'(1) : window_ticks;
    wc_eff = (window_count == '0) ? prtc_pkg::WC_W'(1) : window_count;
    da = ({1'b0, rate} >= D_W'(rate_a)) ? {1'b0, rate} - D_W'(rate_a)
                                         : D_W'(rate_a) - {1'b0, rate};
    db = ({1'b0, rate} >= D_W'(rate_b)) ? {1'b0, rate} - D_W'(rate_b)
                                         : D_W'(rate_b) - {1'b0, rate};
    two_r = {rate, 1'b0};
    sum_ab = D_W'(rate_a) + D_W'(rate_b);
    d = (two_r >= sum_ab) ? two_r - sum_ab : sum_ab - two_r;
    sep = (rate_a >= rate_b) ? rate_a - rate_b : rate_b - rate_a;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    div_start = 1'b0;
    load_out = 1'b0;
    unique case (state)
      prtc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_next = prtc_pkg::BK_MUL;
        end
      end
      prtc_pkg::BK_MUL: state_next = prtc_pkg::BK_RDIV_GO;
      prtc_pkg::BK_RDIV_GO: begin
        div_start = 1'b1;
        state_next = prtc_pkg::BK_RDIV_WAIT;
      end
      prtc_pkg::BK_RDIV_WAIT: begin
        if (div_done) begin
          state_next = prtc_pkg::BK_CLS;
        end
      end
      prtc_pkg::BK_CLS: begin
        if (rate < prtc_pkg::PR_W'(no_signal_rate) || rate_a == rate_b) begin
          state_next = prtc_pkg::BK_DONE;
        end else begin
          state_next = prtc_pkg::BK_CDIV_GO;
        end
      end
      prtc_pkg::BK_CDIV_GO: begin
        div_start = 1'b1;
        state_next = prtc_pkg::BK_CDIV_WAIT;
      end
      prtc_pkg::BK_CDIV_WAIT: begin
        if (div_done) begin
          state_next = prtc_pkg::BK_DONE;
        end
      end
      prtc_pkg::BK_DONE: begin
        if (!out_valid || pop) begin
          load_out = 1'b1;
          state_next = prtc_pkg::BK_IDLE;
        end
      end
      default: state_next = prtc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prtc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      prtc_pkg::BK_IDLE: cyc <= q_data;
      prtc_pkg::BK_MUL: begin
        num <= NUM_W'(cyc) * NUM_W'(TPS_V);
        den <= DEN_W'(wc_eff) * DEN_W'(wt_eff);
      end
      prtc_pkg::BK_RDIV_WAIT: begin
        rate <= (quot > NUM_W'(PR_MAX)) ? PR_MAX : quot[prtc_pkg::PR_W-1:0];
      end
      prtc_pkg::BK_CLS: begin
        num <= NUM_W'(d) * NUM_W'(prtc_pkg::CONF_MAX);
        den <= DEN_W'(sep);
        if (rate < prtc_pkg::PR_W'(no_signal_rate)) begin
          cls <= prtc_pkg::CLS_NONE;
          conf <= '0;
        end else begin
          cls <= (da <= db) ? prtc_pkg::CLS_A : prtc_pkg::CLS_B;
          conf <= prtc_pkg::CONF_MAX;
        end
      end
      prtc_pkg::BK_CDIV_WAIT: begin
        conf <= (quot > NUM_W'(prtc_pkg::CONF_MAX)) ? prtc_pkg::CONF_MAX
                                                    : quot[prtc_pkg::CONF_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pulse_rate <= rate;
      rate_class <= cls;
      confidence <= conf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

@@ hdl/pulse_rate_tone_classifier.sv @@
// Pulse rate tone classifier: config registers, front counter, queue, back classifier.
// Uses prtc_pkg, prtc_front, prtc_fifo and prtc_back.
//
// One tick is taken per clock while push is high and full is low. Ticks that
// end a counting cycle queue a pulse total; the back part turns each total into
// a result with the shared one-bit-per-cycle divider (one pass for the rate, one
// for the confidence where needed). Totals that come faster than the back part
// takes them fill the four-entry queue and raise full.
// Configuration writes take effect at the next edge and belong in idle periods.
`default_nettype none
module pulse_rate_tone_classifier #(
  parameter int TICKS_PER_SECOND = prtc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       falling_edge,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [prtc_pkg::PR_W-1:0]       pulse_rate,
  output logic [prtc_pkg::CLS_W-1:0]      rate_class,
  output logic [prtc_pkg::CONF_W-1:0]     confidence,
  input  wire logic                       wr_en,
  input  wire logic [prtc_pkg::IDX_W-1:0] wr_index,
  input  wire logic [prtc_pkg::CFG_W-1:0] wr_data
);

  logic [prtc_pkg::DEB_W-1:0]  debounce_ticks;
  logic [prtc_pkg::WT_W-1:0]   window_ticks;
  logic [prtc_pkg::WC_W-1:0]   window_count;
  logic [prtc_pkg::RATE_W-1:0] no_signal_rate;
  logic [prtc_pkg::RATE_W-1:0] rate_a;
  logic [prtc_pkg::RATE_W-1:0] rate_b;

  logic                        tick_en;
  logic                        q_push, q_pop, q_empty;
  logic [prtc_pkg::CYC_W-1:0]  q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= prtc_pkg::DEBOUNCE_RST;
      window_ticks <= prtc_pkg::WINDOW_TICKS_RST;
      window_count <= prtc_pkg::WINDOW_COUNT_RST;
      no_signal_rate <= prtc_pkg::NO_SIGNAL_RST;
      rate_a <= prtc_pkg::RATE_A_RST;
      rate_b <= prtc_pkg::RATE_B_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        prtc_pkg::REG_DEBOUNCE:     debounce_ticks <= wr_data[prtc_pkg::DEB_W-1:0];
        prtc_pkg::REG_WINDOW_TICKS: window_ticks <= wr_data[prtc_pkg::WT_W-1:0];
        prtc_pkg::REG_WINDOW_COUNT: window_count <= wr_data[prtc_pkg::WC_W-1:0];
        prtc_pkg::REG_NO_SIGNAL:    no_signal_rate <= wr_data[prtc_pkg::RATE_W-1:0];
        prtc_pkg::REG_RATE_A:       rate_a <= wr_data[prtc_pkg::RATE_W-1:0];
        prtc_pkg::REG_RATE_B:       rate_b <= wr_data[prtc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_en = push && !full;

  prtc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .tick_en       (tick_en),
    .falling_edge  (falling_edge),
    .debounce_ticks(debounce_ticks),
    .window_ticks  (window_ticks),
    .window_count  (window_count),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  prtc_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .wdata(q_wdata),
    .full (full),
    .rd   (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  prtc_back #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (q_rdata),
    .window_ticks  (window_ticks),
    .window_count  (window_count),
    .no_signal_rate(no_signal_rate),
    .rate_a        (rate_a),
    .rate_b        (rate_b),
    .empty         (empty),
    .pop           (pop),
    .pulse_rate    (pulse_rate),
    .rate_class    (rate_class),
    .confidence    (confidence)
  );

endmodule
`default_nettype wire
